/* design/scl_pkg.sv */
// ----------------------------------------------------------------------------
// Serial command line parser package
// Shared widths, character codes, command kinds and the queued item type.
// ----------------------------------------------------------------------------
`default_nettype none

package scl_pkg;

    localparam int LINE_BYTES  = 64;
    localparam int IDX_W       = $clog2(LINE_BYTES);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [IDX_W-1:0] STORE_DEPTH = IDX_W'(LINE_BYTES - 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    typedef enum logic [1:0] {
        KIND_TIME = 2'd0,
        KIND_ZONE = 2'd1,
        KIND_TEXT = 2'd2,
        KIND_MODE = 2'd3
    } t_kind;

    typedef struct packed {
        logic       eol;
        logic [7:0] data;
    } t_line_item;

endpackage

`default_nettype wire

/* design/serial_command_line_parser_core.sv */
// ----------------------------------------------------------------------------
// Serial command line parser core
// Collects received bytes into lines and turns T=, TZ=, M= and MODE= lines
// into number or text results.
//
// Channel   Direction  Handshake                  Payload
// rx        in         i_rx_valid / o_rx_ready    i_rx_byte
// res       out        o_res_valid / i_res_ready  o_command_kind, o_number_value,
//                                                 o_text_char, o_text_valid, o_last
//
// A received byte is written into a four-entry queue; the back end takes one
// queued byte per cycle while it fills a line and none while it walks one.
// A line feed after a non-empty line is taken in a cycle that also reads the
// first stored byte, then the walk checks one byte per cycle while not stalled.
// Text results leave at one per cycle while the result request is taken.
// Reset is synchronous and empties the line; the store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_line_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [1:0]       o_command_kind,
    output logic [31:0]      o_number_value,
    output logic [7:0]       o_text_char,
    output logic             o_text_valid,
    output logic             o_last
);
    import scl_pkg::*;

    logic       push_valid;
    logic       push_ready;
    t_line_item push_item;
    logic       pop_valid;
    logic       pop_ready;
    t_line_item pop_item;

    scl_front u_front (
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    scl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    scl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (pop_valid),
        .o_pop_ready    (pop_ready),
        .i_pop_item     (pop_item),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_command_kind (o_command_kind),
        .o_number_value (o_number_value),
        .o_text_char    (o_text_char),
        .o_text_valid   (o_text_valid),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

/* design/scl_front.sv */
// ----------------------------------------------------------------------------
// Serial command line parser front end
// Accepts received bytes, drops carriage returns and marks line feeds.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_front (
    input  wire logic              i_rx_valid,
    output logic                   o_rx_ready,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_push_valid,
    input  wire logic              i_push_ready,
    output scl_pkg::t_line_item    o_push_item
);
    import scl_pkg::*;

    assign o_rx_ready       = i_push_ready;
    assign o_push_valid     = i_rx_valid && (i_rx_byte != CH_CR);
    assign o_push_item.eol  = (i_rx_byte == CH_LF);
    assign o_push_item.data = i_rx_byte;

endmodule

`default_nettype wire

/* design/scl_queue.sv */
// ----------------------------------------------------------------------------
// Serial command line parser queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_valid,
    output logic                   o_push_ready,
    input  wire scl_pkg::t_line_item i_push_item,
    output logic                   o_pop_valid,
    input  wire logic              i_pop_ready,
    output scl_pkg::t_line_item    o_pop_item
);
    import scl_pkg::*;

    t_line_item        r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_slots[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

/* design/scl_back.sv */
// ----------------------------------------------------------------------------
// Serial command line parser back end
// Keeps the line store, walks each finished non-empty line once per line feed
// and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_pop_valid,
    output logic                   o_pop_ready,
    input  wire scl_pkg::t_line_item i_pop_item,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output logic [1:0]             o_command_kind,
    output logic [31:0]            o_number_value,
    output logic [7:0]             o_text_char,
    output logic                   o_text_valid,
    output logic                   o_last
);
    import scl_pkg::*;

    typedef enum logic [1:0] {
        ST_FILL = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    typedef enum logic [10:0] {
        PH_P0    = 11'b000_0000_0001,
        PH_T1    = 11'b000_0000_0010,
        PH_TZ2   = 11'b000_0000_0100,
        PH_M1    = 11'b000_0000_1000,
        PH_MO2   = 11'b000_0001_0000,
        PH_MOD3  = 11'b000_0010_0000,
        PH_MODE4 = 11'b000_0100_0000,
        PH_BLANK = 11'b000_1000_0000,
        PH_DIGIT = 11'b001_0000_0000,
        PH_TEXT0 = 11'b010_0000_0000,
        PH_TEXT  = 11'b100_0000_0000
    } t_phase;

    t_state           r_state, n_state;
    t_phase           r_ph, n_ph;
    t_kind            r_kind, n_kind;
    logic [IDX_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_end, n_end;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_neg, n_neg;
    logic             r_over, n_over;
    logic [31:0]      r_mag, n_mag;
    logic [7:0]       r_pend, n_pend;
    logic [7:0]       r_mem [LINE_BYTES];
    logic [7:0]       r_rd_data;

    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [31:0]      r_out_num;
    logic [7:0]       r_out_char;
    logic             r_out_tv;
    logic             r_out_last;

    logic             mem_we;
    logic             emit;
    logic             stall;
    logic             slot_free;
    t_kind            e_kind;
    logic [31:0]      e_num;
    logic [7:0]       e_char;
    logic             e_tv;
    logic             e_last;
    logic [7:0]       c;
    logic             term;
    logic             is_dig;
    logic             is_blank;
    logic [35:0]      acc;
    logic [31:0]      num_final;

    assign c         = r_rd_data;
    assign term      = (r_idx == r_end) || (c == CH_NUL);
    assign is_dig    = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_blank  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign acc       = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0} + {32'd0, c[3:0]};
    assign slot_free = !r_out_valid || i_res_ready;
    assign o_pop_ready = (r_state == ST_FILL);

    always_comb begin
        if (r_kind == KIND_ZONE) begin
            if (r_neg) begin
                num_final = (r_over || (r_mag > 32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - r_mag);
            end else begin
                num_final = (r_over || (r_mag > 32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r_mag;
            end
        end else begin
            if (r_over) begin
                num_final = 32'hFFFF_FFFF;
            end else begin
                num_final = r_neg ? (32'd0 - r_mag) : r_mag;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_kind  = r_kind;
        n_len   = r_len;
        n_end   = r_end;
        n_idx   = r_idx;
        n_neg   = r_neg;
        n_over  = r_over;
        n_mag   = r_mag;
        n_pend  = r_pend;
        mem_we  = 1'b0;
        emit    = 1'b0;
        e_kind  = r_kind;
        e_num   = 32'd0;
        e_char  = 8'd0;
        e_tv    = 1'b0;
        e_last  = 1'b1;

        unique case (r_state)
            ST_FILL: begin
                if (i_pop_valid) begin
                    if (!i_pop_item.eol) begin
                        if (r_len < STORE_DEPTH) begin
                            mem_we = 1'b1;
                            n_len  = r_len + 1'b1;
                        end else begin
                            n_len = '0;
                        end
                    end else begin
                        n_len = '0;
                        if (r_len != '0) begin
                            n_end   = r_len;
                            n_idx   = '0;
                            n_ph    = PH_P0;
                            n_neg   = 1'b0;
                            n_over  = 1'b0;
                            n_mag   = 32'd0;
                            n_state = ST_WALK;
                        end
                    end
                end
            end
            ST_WALK: begin
                n_idx = r_idx + 1'b1;
                unique case (r_ph)
                    PH_P0: begin
                        if (!term && (c == CH_T)) begin
                            n_ph = PH_T1;
                        end else if (!term && (c == CH_M)) begin
                            n_ph = PH_M1;
                        end else begin
                            n_state = ST_FILL;
                        end
                    end
                    PH_T1: begin
                        if (!term && (c == CH_EQ)) begin
                            n_kind = KIND_TIME;
                            n_ph   = PH_BLANK;
                        end else if (!term && (c == CH_Z)) begin
                            n_ph = PH_TZ2;
                        end else begin
                            n_state = ST_FILL;
                        end
                    end
                    PH_TZ2: begin
                        if (!term && (c == CH_EQ)) begin
                            n_kind = KIND_ZONE;
                            n_ph   = PH_BLANK;
                        end else begin
                            n_state = ST_FILL;
                        end
                    end
                    PH_M1: begin
                        if (!term && (c == CH_EQ)) begin
                            n_kind = KIND_TEXT;
                            n_ph   = PH_TEXT0;
                        end else if (!term && (c == CH_O)) begin
                            n_ph = PH_MO2;
                        end else begin
                            n_state = ST_FILL;
                        end
                    end
                    PH_MO2: begin
                        if (!term && (c == CH_D)) begin
                            n_ph = PH_MOD3;
                        end else begin
                            n_state = ST_FILL;
                        end
                    end
                    PH_MOD3: begin
                        if (!term && (c == CH_E)) begin
                            n_ph = PH_MODE4;
                        end else begin
                            n_state = ST_FILL;
                        end
                    end
                    PH_MODE4: begin
                        if (!term && (c == CH_EQ)) begin
                            n_kind = KIND_MODE;
                            n_ph   = PH_TEXT0;
                        end else begin
                            n_state = ST_FILL;
                        end
                    end
                    PH_BLANK: begin
                        if (term) begin
                            emit    = 1'b1;
                            e_num   = num_final;
                            n_state = ST_FILL;
                        end else if (is_blank) begin
                            n_ph = PH_BLANK;
                        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                            n_neg = (c == CH_MINUS);
                            n_ph  = PH_DIGIT;
                        end else if (is_dig) begin
                            n_mag = acc[31:0];
                            n_ph  = PH_DIGIT;
                        end else begin
                            emit    = 1'b1;
                            e_num   = num_final;
                            n_state = ST_FILL;
                        end
                    end
                    PH_DIGIT: begin
                        if (term || !is_dig) begin
                            emit    = 1'b1;
                            e_num   = num_final;
                            n_state = ST_FILL;
                        end else if (!r_over) begin
                            if (acc[35:32] != 4'd0) begin
                                n_over = 1'b1;
                            end else begin
                                n_mag = acc[31:0];
                            end
                        end
                    end
                    PH_TEXT0: begin
                        if (term) begin
                            emit    = 1'b1;
                            n_state = ST_FILL;
                        end else begin
                            n_pend = c;
                            n_ph   = PH_TEXT;
                        end
                    end
                    PH_TEXT: begin
                        emit   = 1'b1;
                        e_char = r_pend;
                        e_tv   = 1'b1;
                        if (term) begin
                            n_state = ST_FILL;
                        end else begin
                            e_last = 1'b0;
                            n_pend = c;
                        end
                    end
                    default: begin
                        n_state = ST_FILL;
                    end
                endcase
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase

        stall = emit && !slot_free;
        if (stall) begin
            n_state = r_state;
            n_ph    = r_ph;
            n_kind  = r_kind;
            n_idx   = r_idx;
            n_neg   = r_neg;
            n_over  = r_over;
            n_mag   = r_mag;
            n_pend  = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_ph        <= PH_P0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_len   <= n_len;
            if (emit && !stall) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_end  <= n_end;
        r_idx  <= n_idx;
        r_neg  <= n_neg;
        r_over <= n_over;
        r_mag  <= n_mag;
        r_pend <= n_pend;
        if (emit && !stall) begin
            r_out_kind <= e_kind;
            r_out_num  <= e_num;
            r_out_char <= e_char;
            r_out_tv   <= e_tv;
            r_out_last <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_len] <= i_pop_item.data;
        end
        r_rd_data <= r_mem[n_idx];
    end

    assign o_res_valid    = r_out_valid;
    assign o_command_kind = r_out_kind;
    assign o_number_value = r_out_num;
    assign o_text_char    = r_out_char;
    assign o_text_valid   = r_out_tv;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire
